// ===== design/nfr_pkg.sv =====
// Shared types, constants and the CRC-8 step for the nibble frame receiver.
`default_nettype none
package nfr_pkg;

    localparam int MAX_FRAME_BYTES = 64;

    localparam logic [7:0]  SYM_STX       = 8'h02;
    localparam logic [7:0]  SYM_ETX       = 8'h03;
    localparam logic [7:0]  CRC_POLY      = 8'h8C;
    localparam logic [3:0]  NIBBLE_MASK   = 4'hF;
    localparam logic [15:0] TIMEOUT_RESET = 16'd1000;
    localparam logic [15:0] TICKS_MAX     = 16'hFFFF;

    localparam logic [7:0]  MAX_BYTES = 8'(MAX_FRAME_BYTES);

    localparam logic REQ_BYTE = 1'b0;
    localparam logic REQ_TICK = 1'b1;

    localparam logic KIND_DATA   = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_BAD_CRC = 2'd1;
    localparam logic [1:0] ST_OVERFLOW = 2'd2;
    localparam logic [1:0] ST_TIMEOUT = 2'd3;

    // Register byte-address bit that selects the register (one register, at 0)
    localparam logic REG_TIMEOUT = 1'b0;

    typedef struct packed {
        logic       valid;
        logic       kind;
        logic [7:0] data;
        logic [1:0] status;
        logic [7:0] len;
    } t_result;

    // Reflected CRC-8, one byte
    function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        logic [7:0] d;
        logic       mix;
        c = crc;
        d = b;
        for (int i = 0; i < 8; i++) begin
            mix = c[0] ^ d[0];
            c = c >> 1;
            if (mix) begin
                c = c ^ CRC_POLY;
            end
            d = d >> 1;
        end
        return c;
    endfunction

endpackage
`default_nettype wire

// ===== design/nfr_decoder.sv =====
// Frame state, nibble decode, CRC and timeout; produces at most one result per item.
`default_nettype none
module nfr_decoder (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_accept,
    input  wire logic            i_req_type,
    input  wire logic [7:0]      i_rx_byte,
    input  wire logic [15:0]     i_timeout_ticks,
    output nfr_pkg::t_result     o_result
);
    import nfr_pkg::*;

    logic        r_in_frame,    n_in_frame;
    logic        r_expect_high, n_expect_high;
    logic [3:0]  r_high_nibble, n_high_nibble;
    logic [7:0]  r_byte_count,  n_byte_count;
    logic [7:0]  r_held_byte,   n_held_byte;
    logic [7:0]  r_crc,         n_crc;
    logic [15:0] r_elapsed,     n_elapsed;
    t_result     res;

    always_comb begin
        logic        go_idle;
        logic        open_frame;
        logic        code_ok;
        logic [15:0] ticks;
        go_idle       = 1'b0;
        open_frame    = 1'b0;
        res           = '0;
        n_in_frame    = r_in_frame;
        n_expect_high = r_expect_high;
        n_high_nibble = r_high_nibble;
        n_byte_count  = r_byte_count;
        n_held_byte   = r_held_byte;
        n_crc         = r_crc;
        ticks         = (r_elapsed == TICKS_MAX) ? r_elapsed : r_elapsed + 16'd1;
        n_elapsed     = r_elapsed;
        code_ok       = (i_rx_byte[7:4] == (i_rx_byte[3:0] ^ NIBBLE_MASK));

        if (i_req_type == REQ_TICK) begin
            n_elapsed = ticks;
            if (ticks >= i_timeout_ticks) begin
                res.valid  = 1'b1;
                res.kind   = KIND_STATUS;
                res.status = ST_TIMEOUT;
                go_idle    = 1'b1;
            end
        end else if (i_rx_byte == SYM_STX) begin
            go_idle    = 1'b1;
            open_frame = 1'b1;
        end else if (i_rx_byte == SYM_ETX) begin
            res.valid = 1'b1;
            res.kind  = KIND_STATUS;
            go_idle   = 1'b1;
            if (r_byte_count == 8'd0) begin
                res.status = ST_BAD_CRC;
            end else begin
                res.status = (r_crc == r_held_byte) ? ST_OK : ST_BAD_CRC;
                res.len    = r_byte_count - 8'd1;
            end
        end else if (code_ok && r_in_frame) begin
            if (r_expect_high) begin
                n_high_nibble = i_rx_byte[7:4];
                n_expect_high = 1'b0;
            end else begin
                n_expect_high = 1'b1;
                if (r_byte_count >= MAX_BYTES) begin
                    res.valid  = 1'b1;
                    res.kind   = KIND_STATUS;
                    res.status = ST_OVERFLOW;
                    go_idle    = 1'b1;
                end else begin
                    if (r_byte_count != 8'd0) begin
                        res.valid = 1'b1;
                        res.kind  = KIND_DATA;
                        res.data  = r_held_byte;
                        n_crc     = crc8_step(r_crc, r_held_byte);
                    end
                    n_held_byte  = {r_high_nibble, i_rx_byte[7:4]};
                    n_byte_count = r_byte_count + 8'd1;
                end
            end
        end

        if (go_idle) begin
            n_in_frame    = open_frame;
            n_expect_high = 1'b1;
            n_high_nibble = '0;
            n_byte_count  = '0;
            n_held_byte   = '0;
            n_crc         = '0;
            n_elapsed     = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_frame    <= 1'b0;
            r_expect_high <= 1'b1;
            r_high_nibble <= '0;
            r_byte_count  <= '0;
            r_held_byte   <= '0;
            r_crc         <= '0;
            r_elapsed     <= '0;
        end else if (i_accept) begin
            r_in_frame    <= n_in_frame;
            r_expect_high <= n_expect_high;
            r_high_nibble <= n_high_nibble;
            r_byte_count  <= n_byte_count;
            r_held_byte   <= n_held_byte;
            r_crc         <= n_crc;
            r_elapsed     <= n_elapsed;
        end
    end

    assign o_result = res;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_byte_count <= MAX_BYTES)
        else $error("byte count beyond frame limit");

    a_status_idles: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && res.valid && res.kind == KIND_STATUS)
        |=> (!r_in_frame && r_byte_count == 8'd0 && r_elapsed == 16'd0))
        else $error("status did not return to idle");

    a_data_in_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (res.valid && res.kind == KIND_DATA) |-> (r_in_frame && r_byte_count != 8'd0))
        else $error("data item outside a frame");

endmodule
`default_nettype wire

// ===== design/nibble_frame_receiver.sv =====
// Top level of the nibble frame receiver: stream ports, output register, APB register.
// Each input item is either a line byte or a timer tick; one item is taken every cycle
// and yields zero or one result item, registered in a single output register and shown
// in the next cycle, so the rate is one item per clock while the sink keeps up.
// A decoded payload byte is emitted when the next byte completes, so the trailing CRC
// byte never appears; ETX, overflow and timeout each give a status item and reset the
// frame state. timeout_ticks (reset 1000) lives at APB address 0.
`default_nettype none
module nibble_frame_receiver (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // input stream
    input  wire logic        i_s_axis_tvalid,
    output      logic        o_s_axis_tready,
    input  wire logic [7:0]  i_s_axis_tdata,   // [7:0] rx_byte
    input  wire logic        i_s_axis_tuser,   // [0] req_type
    // result stream
    output      logic        o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    output      logic [23:0] o_m_axis_tdata,   // [7:0] data_byte, [9:8] frame_status,
                                               // [17:10] payload_length, [23:18] zero
    output      logic        o_m_axis_tuser,   // [0] result_kind
    // configuration
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output      logic [31:0] prdata,
    output      logic        pready
);
    import nfr_pkg::*;

    logic [15:0] r_timeout_ticks;
    logic        r_out_valid;
    logic        r_out_kind;
    logic [23:0] r_out_data;
    logic        in_accept;
    t_result     result;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_TIMEOUT) ? {16'd0, r_timeout_ticks} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout_ticks <= TIMEOUT_RESET;
        end else if (psel && penable && pwrite && pready && paddr[2] == REG_TIMEOUT) begin
            r_timeout_ticks <= pwdata[15:0];
        end
    end

    assign o_s_axis_tready = !r_out_valid || i_m_axis_tready;
    assign in_accept       = i_s_axis_tvalid && o_s_axis_tready;

    nfr_decoder u_decoder (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_accept        (in_accept),
        .i_req_type      (i_s_axis_tuser),
        .i_rx_byte       (i_s_axis_tdata),
        .i_timeout_ticks (r_timeout_ticks),
        .o_result        (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_accept) begin
            r_out_valid <= result.valid;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_out_kind <= result.kind;
            r_out_data <= {6'd0, result.len, result.status, result.data};
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tuser  = r_out_kind;
    assign o_m_axis_tdata  = r_out_data;

    a_result_loaded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && result.valid) |=> r_out_valid)
        else $error("result lost at output register");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_m_axis_tready) |-> !in_accept)
        else $error("input taken while result stalled");

    a_cfg_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (psel && penable && pwrite && paddr[2] == REG_TIMEOUT)
        |=> (r_timeout_ticks == $past(pwdata[15:0])))
        else $error("timeout register not written");

endmodule
`default_nettype wire

// ===== tb/sv/nibble_frame_receiver_tb.sv =====
// Self-checking testbench for nibble_frame_receiver: streamed frames, ticks and APB timeout setup.
module nibble_frame_receiver_tb;
    import nfr_pkg::*;

    typedef struct packed {
        logic       is_tick;
        logic [7:0] rx;
    } t_line_item;

    typedef struct packed {
        logic       kind;
        logic [7:0] data;
        logic [1:0] status;
        logic [7:0] len;
    } t_frame_result;

    localparam logic [2:0] ADDR_TIMEOUT   = 3'd0;
    localparam int         WATCHDOG_LIMIT = 2000;
    localparam int         DRAIN_CYCLES   = 4;
    localparam int         PHASE_ITEMS    = 360;

    logic        i_clk   = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_valid = 1'b0;
    logic [7:0]  s_data  = 8'h00;
    logic        s_user  = 1'b0;
    logic        m_ready = 1'b0;
    logic        psel    = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite  = 1'b0;
    logic [2:0]  paddr   = 3'd0;
    logic [31:0] pwdata  = 32'd0;

    wire logic        o_s_axis_tready;
    wire logic        o_m_axis_tvalid;
    wire logic [23:0] o_m_axis_tdata;
    wire logic        o_m_axis_tuser;
    wire logic [31:0] prdata;
    wire logic        pready;

    nibble_frame_receiver uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (s_data),
        .i_s_axis_tuser  (s_user),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    always #6 i_clk = ~i_clk;

    t_line_item    pending[$];
    t_frame_result exp_results[$];
    int            queued_total   = 0;
    int            accepted_total = 0;
    int            errors         = 0;
    int            quiet_cycles   = 0;
    int            send_gap_pct   = 0;
    int            sink_stall_pct = 0;
    logic          in_fire        = 1'b0;

    // receiver model state
    logic [15:0] cfg_timeout = TIMEOUT_RESET;
    logic        rx_in_frame = 1'b0;
    logic        rx_want_high = 1'b1;
    logic [3:0]  rx_high = 4'h0;
    logic [7:0]  rx_count = 8'h00;
    logic [7:0]  rx_held = 8'h00;
    logic [7:0]  rx_crc = 8'h00;
    logic [15:0] rx_elapsed = 16'h0000;

    function automatic logic [7:0] crc8_next(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc;
        for (int i = 0; i < 8; i++) begin
            c = (c >> 1) ^ (((c[0] ^ b[i]) == 1'b1) ? CRC_POLY : 8'h00);
        end
        return c;
    endfunction

    task automatic clear_frame();
        rx_in_frame  = 1'b0;
        rx_want_high = 1'b1;
        rx_high      = 4'h0;
        rx_count     = 8'h00;
        rx_held      = 8'h00;
        rx_crc       = 8'h00;
        rx_elapsed   = 16'h0000;
    endtask

    task automatic post_status(input logic [1:0] st, input logic [7:0] len);
        exp_results.push_back({KIND_STATUS, 8'h00, st, len});
        clear_frame();
    endtask

    task automatic predict_item(input t_line_item it);
        logic [7:0] full;
        if (it.is_tick == REQ_TICK) begin
            if (rx_elapsed != TICKS_MAX) rx_elapsed = rx_elapsed + 16'd1;
            if (rx_elapsed >= cfg_timeout) post_status(ST_TIMEOUT, 8'h00);
        end else if (it.rx == SYM_STX) begin
            clear_frame();
            rx_in_frame = 1'b1;
        end else if (it.rx == SYM_ETX) begin
            if (rx_count == 8'h00) begin
                post_status(ST_BAD_CRC, 8'h00);
            end else begin
                post_status((rx_crc == rx_held) ? ST_OK : ST_BAD_CRC, rx_count - 8'd1);
            end
        end else if (rx_in_frame && it.rx[7:4] == (it.rx[3:0] ^ NIBBLE_MASK)) begin
            if (rx_want_high) begin
                rx_high      = it.rx[7:4];
                rx_want_high = 1'b0;
            end else begin
                full         = {rx_high, it.rx[7:4]};
                rx_want_high = 1'b1;
                if (rx_count >= MAX_BYTES) begin
                    post_status(ST_OVERFLOW, 8'h00);
                end else begin
                    if (rx_count != 8'h00) begin
                        exp_results.push_back({KIND_DATA, rx_held, ST_OK, 8'h00});
                        rx_crc = crc8_next(rx_crc, rx_held);
                    end
                    rx_held  = full;
                    rx_count = rx_count + 8'd1;
                end
            end
        end
    endtask

    task automatic put_item(input logic is_tick, input logic [7:0] rx);
        pending.push_back({is_tick, rx});
        queued_total++;
    endtask

    task automatic put_noise();
        if ($urandom_range(1, 0) == 1) put_item(REQ_TICK, 8'($urandom_range(255, 0)));
        else put_item(REQ_BYTE, 8'($urandom_range(255, 0)));
    endtask

    task automatic put_code(input logic [7:0] b, input int noise_pct);
        put_item(REQ_BYTE, {b[7:4], b[7:4] ^ NIBBLE_MASK});
        if ($urandom_range(99, 0) < noise_pct) put_noise();
        put_item(REQ_BYTE, {b[3:0], b[3:0] ^ NIBBLE_MASK});
    endtask

    task automatic queue_frame();
        int         n;
        logic [7:0] b;
        logic [7:0] crc;
        if ($urandom_range(9, 0) == 0) n = $urandom_range(MAX_FRAME_BYTES, MAX_FRAME_BYTES - 2);
        else n = $urandom_range(12, 0);
        crc = 8'h00;
        put_item(REQ_BYTE, SYM_STX);
        for (int i = 0; i < n; i++) begin
            b = 8'($urandom_range(255, 0));
            put_code(b, 4);
            crc = crc8_next(crc, b);
        end
        if ($urandom_range(99, 0) < 15) crc = crc ^ 8'($urandom_range(255, 1));
        put_code(crc, 4);
        if ($urandom_range(99, 0) < 95) put_item(REQ_BYTE, SYM_ETX);
    endtask

    task automatic queue_random(input int budget);
        int stop_at;
        int r;
        stop_at = queued_total + budget;
        while (queued_total < stop_at) begin
            r = $urandom_range(99, 0);
            if (r < 72) begin
                queue_frame();
            end else if (r < 84) begin
                repeat ($urandom_range(16, 1)) put_item(REQ_TICK, 8'($urandom_range(255, 0)));
            end else if (r < 92) begin
                put_item(REQ_BYTE, {4'($urandom_range(15, 0)), 4'h0} ^ 8'h0F
                         ^ {4'h0, 4'hF} ^ {4'h0, 4'hF});
            end else begin
                repeat ($urandom_range(4, 1)) put_noise();
            end
        end
    endtask

    task automatic wait_drained();
        while (accepted_total != queued_total || exp_results.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_timeout(input logic [15:0] value);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= ADDR_TIMEOUT;
        pwdata  <= {16'h0000, value};
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        cfg_timeout = value;
    endtask

    always @(negedge i_clk) begin : driver
        t_line_item nxt;
        logic       hold;
        hold = s_valid && !in_fire;
        if (i_rst_n && !hold && pending.size() != 0 && $urandom_range(99, 0) >= send_gap_pct) begin
            nxt = pending.pop_front();
            s_user <= nxt.is_tick;
            s_data <= nxt.rx;
            hold = 1'b1;
        end
        s_valid <= hold;
        m_ready <= ($urandom_range(99, 0) >= sink_stall_pct);
    end

    always @(posedge i_clk) begin : monitor
        t_frame_result got;
        t_frame_result want;
        logic          out_fire;
        logic          take;
        out_fire = i_rst_n && o_m_axis_tvalid && m_ready;
        take     = i_rst_n && s_valid && o_s_axis_tready;
        if (out_fire) begin
            got = {o_m_axis_tuser, o_m_axis_tdata[7:0], o_m_axis_tdata[9:8], o_m_axis_tdata[17:10]};
            if (exp_results.size() == 0) begin
                errors++;
                $display("%0t unexpected result: kind=%0d data=%02h status=%0d len=%0d",
                         $time, got.kind, got.data, got.status, got.len);
            end else begin
                want = exp_results.pop_front();
                if (got.kind !== want.kind || got.data !== want.data ||
                    got.status !== want.status || got.len !== want.len ||
                    o_m_axis_tdata[23:18] !== 6'd0) begin
                    errors++;
                    $display("%0t mismatch: expected kind=%0d data=%02h status=%0d len=%0d, %s",
                             $time, want.kind, want.data, want.status, want.len,
                             $sformatf("actual kind=%0d data=%02h status=%0d len=%0d pad=%02h",
                                       got.kind, got.data, got.status, got.len,
                                       o_m_axis_tdata[23:18]));
                end
            end
        end
        if (take) begin
            predict_item({s_user, s_data});
            accepted_total++;
        end
        in_fire <= take;
        if (!i_rst_n || out_fire || take) quiet_cycles = 0;
        else quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t watchdog: no item moved for %0d cycles", $time, quiet_cycles);
            $display("status: fail");
            $finish;
        end
    end

    initial begin : stimulus
        logic [7:0] crc;
        send_gap_pct   = 28;
        sink_stall_pct = 51;
        repeat (2) @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed, timeout at its reset value
        put_item(REQ_BYTE, SYM_ETX);           // ETX while idle
        put_item(REQ_BYTE, 8'hF0);             // nibble code outside a frame
        put_item(REQ_BYTE, SYM_STX);
        put_code(8'h00, 0);
        put_item(REQ_BYTE, 8'hFF);             // not a nibble code
        put_code(8'hFF, 0);
        crc = crc8_next(crc8_next(8'h00, 8'h00), 8'hFF);
        put_code(crc, 0);
        put_item(REQ_BYTE, SYM_ETX);
        put_item(REQ_BYTE, SYM_STX);
        put_code(8'hA5, 0);
        put_item(REQ_BYTE, 8'h3C);             // lone high nibble before ETX
        put_item(REQ_BYTE, SYM_ETX);
        put_item(REQ_BYTE, SYM_STX);
        put_code(8'h12, 0);
        put_item(REQ_BYTE, SYM_STX);           // restart drops the byte so far
        put_code(8'h34, 0);
        put_code(crc8_next(8'h00, 8'h34), 0);
        put_item(REQ_BYTE, SYM_ETX);
        repeat (3) put_item(REQ_TICK, 8'hFF);
        wait_drained();

        write_timeout(16'd2);
        put_item(REQ_TICK, 8'h00);
        put_item(REQ_TICK, 8'h5A);
        wait_drained();

        write_timeout(16'd12);
        queue_random(PHASE_ITEMS);
        wait_drained();

        send_gap_pct   = 51;
        sink_stall_pct = 28;
        write_timeout(16'd0);
        queue_random(PHASE_ITEMS);
        wait_drained();

        send_gap_pct   = 0;
        sink_stall_pct = 0;
        write_timeout(16'hFFFF);
        queue_random(PHASE_ITEMS);
        wait_drained();

        if (errors == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
